FILE: hdl/dbs_pkg.sv
`timescale 1ns / 1ps

package dbs_pkg;

   // geometry of the store
   localparam int CAPACITY    = 16;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W       = $clog2(CAPACITY + 1);

   // request op codes
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CONTAINS   = 3'd4,
      OP_REMOVE     = 3'd5
   } op_type;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_OVERFLOW  = 2'd1;
   localparam logic [1:0] STAT_UNDERFLOW = 2'd2;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SEARCH,
      ST_SHIFT,
      ST_RD_FRONT,
      ST_RD_BACK,
      ST_FINISH
   } state_type;

   // request word
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] value;
   } req_type;

   // result word
   typedef struct packed {
      logic [1:0]         status;
      logic               found;
      logic [4:0]         count;
      logic               is_empty;
      logic               is_full;
      logic signed [31:0] front_value;
      logic signed [31:0] back_value;
   } rsp_type;

   // port group toward the entry memory
   typedef struct packed {
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic [IDX_W-1:0]       rd_addr;
   } mem_req_type;

   // sign-extend a 32-bit word, then keep VALUE_WIDTH bits
   function automatic logic [VALUE_WIDTH-1:0] to_stored(input logic signed [31:0] x);
      logic signed [63:0] ext;
      ext = 64'(x);
      return ext[VALUE_WIDTH-1:0];
   endfunction

   // sign-extend a stored entry, then keep 32 bits
   function automatic logic signed [31:0] to_out(input logic [VALUE_WIDTH-1:0] s);
      logic signed [63:0] ext;
      ext = 64'(signed'(s));
      return ext[31:0];
   endfunction

endpackage

FILE: hdl/deque_bag_store_top.sv
`timescale 1ns / 1ps

// channel  | ports                      | handshake
// ---------+----------------------------+---------------------------------------
// request  | start, busy, req_data      | word taken when start high, busy low
// result   | rsp_strobe, rsp_data       | word valid for one cycle on strobe
//
// push and pop: exec, front read, back read, finish, output register; the back read
// is skipped when the store ends empty. contains reads and compares one ring entry
// at a time from the front to the first match; remove shifts the later ones forward.
// the entry memory has one write port and one registered read port.
// reset is synchronous, active high: store empty, head at zero, no strobe.
// results cannot be stalled; the next word is taken once busy falls.

module deque_bag_store_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  dbs_pkg::req_type req_data,
   output logic             rsp_strobe,
   output dbs_pkg::rsp_type rsp_data
);
   import dbs_pkg::*;

   mem_req_type            mem_req;
   logic [VALUE_WIDTH-1:0] rd_data;
   logic                   done;
   rsp_type                rsp;
   logic                   rsp_strobe_ff;
   rsp_type                rsp_ff;

   dbs_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_data),
      .busy    (busy),
      .done    (done),
      .rsp     (rsp),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   dbs_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= rsp;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // one result per word, never on adjacent cycles
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe on adjacent cycles");

   // empty flag agrees with the count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.is_empty == (rsp_data.count == 5'd0)))
      else $error("empty flag disagrees with count");

   // empty store reports zero ends
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.is_empty) |->
         (rsp_data.front_value == 32'sd0 && rsp_data.back_value == 32'sd0))
      else $error("empty store reports nonzero end values");

endmodule

FILE: hdl/dbs_ram.sv
`timescale 1ns / 1ps

module dbs_ram (
   input  logic                               clock,
   input  dbs_pkg::mem_req_type               mem_req,
   output logic [dbs_pkg::VALUE_WIDTH-1:0]    rd_data
);
   import dbs_pkg::*;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   // one write port
   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   // one registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[mem_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/dbs_ctrl.sv
`timescale 1ns / 1ps

module dbs_ctrl (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  dbs_pkg::req_type                req,
   output logic                            busy,
   output logic                            done,
   output dbs_pkg::rsp_type                rsp,
   output dbs_pkg::mem_req_type            mem_req,
   input  logic [dbs_pkg::VALUE_WIDTH-1:0] rd_data
);
   import dbs_pkg::*;

   localparam int SUM_W = CNT_W + 1;

   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [IDX_W-1:0]       head_ff, head_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [1:0]             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [CNT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]       sh_idx_ff, sh_idx_in;
   logic                   sh_pend_ff, sh_pend_in;
   logic [CNT_W-1:0]       wr_pos_ff, wr_pos_in;
   logic [VALUE_WIDTH-1:0] front_ff, front_in;
   logic                   is_empty, is_full;
   logic                   match;

   // ring position of a logical place counted from a base
   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(pos);
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign is_empty = (cnt_ff == '0);
   assign is_full  = (cnt_ff == CNT_W'(CAPACITY));
   assign match    = cmp_vld_ff && (rd_data == val_ff);
   assign busy     = (state_ff != ST_IDLE);

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         head_ff    <= '0;
         cnt_ff     <= '0;
         cmp_vld_ff <= 1'b0;
         sh_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         head_ff    <= head_in;
         cnt_ff     <= cnt_in;
         cmp_vld_ff <= cmp_vld_in;
         sh_pend_ff <= sh_pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      rd_idx_ff  <= rd_idx_in;
      cmp_idx_ff <= cmp_idx_in;
      sh_idx_ff  <= sh_idx_in;
      wr_pos_ff  <= wr_pos_in;
      front_ff   <= front_in;
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      head_in    = head_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      rd_idx_in  = rd_idx_ff;
      cmp_idx_in = cmp_idx_ff;
      cmp_vld_in = 1'b0;
      sh_idx_in  = sh_idx_ff;
      sh_pend_in = 1'b0;
      wr_pos_in  = wr_pos_ff;
      front_in   = front_ff;
      done       = 1'b0;
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = slot_of(head_ff, cnt_ff);
      mem_req.wr_data = val_ff;
      mem_req.rd_addr = slot_of(head_ff, rd_idx_ff);
      rsp.status      = status_ff;
      rsp.found       = found_ff;
      rsp.count       = 5'(cnt_ff);
      rsp.is_empty    = is_empty;
      rsp.is_full     = is_full;
      rsp.front_value = is_empty ? 32'sd0 : to_out(front_ff);
      rsp.back_value  = is_empty ? 32'sd0 : to_out(rd_data);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in     = op_type'(req.op);
               val_in    = to_stored(req.value);
               status_in = STAT_OK;
               found_in  = 1'b0;
               state_in  = ST_EXEC;
            end
         end

         // single-step ops, or set up the walk
         ST_EXEC: begin
            state_in   = ST_RD_FRONT;
            rd_idx_in  = '0;
            unique case (op_ff)
               OP_PUSH_FRONT: begin
                  if (is_full) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     head_in = (head_ff == '0) ? IDX_W'(CAPACITY - 1)
                                               : head_ff - IDX_W'(1);
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_addr = head_in;
                     cnt_in          = cnt_ff + CNT_W'(1);
                  end
               end
               OP_PUSH_BACK: begin
                  if (is_full) begin
                     status_in = STAT_OVERFLOW;
                  end else begin
                     mem_req.wr_en = 1'b1;
                     cnt_in        = cnt_ff + CNT_W'(1);
                  end
               end
               OP_POP_FRONT: begin
                  if (is_empty) begin
                     status_in = STAT_UNDERFLOW;
                  end else begin
                     head_in = slot_of(head_ff, CNT_W'(1));
                     cnt_in  = cnt_ff - CNT_W'(1);
                  end
               end
               OP_POP_BACK: begin
                  if (is_empty) begin
                     status_in = STAT_UNDERFLOW;
                  end else begin
                     cnt_in = cnt_ff - CNT_W'(1);
                  end
               end
               OP_CONTAINS, OP_REMOVE: begin
                  if (!is_empty) begin
                     state_in = ST_SEARCH;
                  end
               end
               default: begin
               end
            endcase
         end

         // one read issued and one compare done each cycle
         ST_SEARCH: begin
            if (rd_idx_ff < cnt_ff) begin
               rd_idx_in  = rd_idx_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff;
            end
            if (match) begin
               found_in   = 1'b1;
               cmp_vld_in = 1'b0;
               sh_idx_in  = cmp_idx_ff + CNT_W'(1);
               state_in   = (op_ff == OP_REMOVE) ? ST_SHIFT : ST_RD_FRONT;
            end else if (!cmp_vld_ff && (rd_idx_ff >= cnt_ff)) begin
               cmp_vld_in = 1'b0;
               state_in   = ST_RD_FRONT;
            end
         end

         // close the gap: read place j, write it to place j-1 next cycle
         ST_SHIFT: begin
            mem_req.rd_addr = slot_of(head_ff, sh_idx_ff);
            mem_req.wr_en   = sh_pend_ff;
            mem_req.wr_addr = slot_of(head_ff, wr_pos_ff);
            mem_req.wr_data = rd_data;
            if (sh_idx_ff < cnt_ff) begin
               sh_pend_in = 1'b1;
               wr_pos_in  = sh_idx_ff - CNT_W'(1);
               sh_idx_in  = sh_idx_ff + CNT_W'(1);
            end else if (!sh_pend_ff) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = ST_RD_FRONT;
            end
         end

         // fetch the front and back entries
         ST_RD_FRONT: begin
            mem_req.rd_addr = slot_of(head_ff, '0);
            state_in        = is_empty ? ST_FINISH : ST_RD_BACK;
         end

         ST_RD_BACK: begin
            mem_req.rd_addr = slot_of(head_ff, cnt_ff - CNT_W'(1));
            front_in        = rd_data;
            state_in        = ST_FINISH;
         end

         ST_FINISH: begin
            done     = 1'b1;
            state_in = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

FILE: verif/tb_deque_bag_store_top.sv
`timescale 1ns / 1ps

module tb_deque_bag_store_top;
   import dbs_pkg::*;

   // op codes with no defined action, the block answers with a plain report
   localparam logic [2:0] OP_UNUSED_A = 3'd6;
   localparam logic [2:0] OP_UNUSED_B = 3'd7;

   // random op mix for a run of words
   typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} op_mix_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   deque_bag_store_top dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   // request words waiting to go out, result words owed by the block
   req_type            pending_reqs[$];
   rsp_type            owed_rsps[$];
   rsp_type            due_rsp;
   int                 gap_pct = 0;
   int                 mismatch_cnt = 0;
   logic signed [31:0] value_pool[8];

   // shadow copy of the ring
   logic signed [31:0] ring[CAPACITY];
   int                 head = 0;
   int                 fill = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   task automatic log_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_cnt++;
   endtask

   task automatic field_check(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         log_mismatch($sformatf("%s got %h want %h", name, got, want));
   endtask

   // apply one request word to the shadow ring and build the result word
   function automatic rsp_type deque_apply(input req_type r);
      rsp_type o;
      int      pos;
      int      k;
      bit      hit;
      o = '0;
      pos = 0;
      hit = 1'b0;
      case (r.op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (fill == CAPACITY) begin
               o.status = STAT_OVERFLOW;
            end else if (r.op == OP_PUSH_FRONT) begin
               head = (head + CAPACITY - 1) % CAPACITY;
               ring[4'(head)] = r.value;
               fill++;
            end else begin
               ring[4'((head + fill) % CAPACITY)] = r.value;
               fill++;
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (fill == 0) begin
               o.status = STAT_UNDERFLOW;
            end else begin
               if (r.op == OP_POP_FRONT)
                  head = (head + 1) % CAPACITY;
               fill--;
            end
         end
         OP_CONTAINS, OP_REMOVE: begin
            // first match counted from the front
            while (pos < fill && !hit) begin
               if (ring[4'((head + pos) % CAPACITY)] == r.value)
                  hit = 1'b1;
               else
                  pos++;
            end
            o.found = hit;
            // close the gap toward the front
            if (hit && r.op == OP_REMOVE) begin
               for (k = pos; k + 1 < fill; k++)
                  ring[4'((head + k) % CAPACITY)] = ring[4'((head + k + 1) % CAPACITY)];
               fill--;
            end
         end
         default: ;
      endcase
      o.count    = 5'(fill);
      o.is_empty = (fill == 0);
      o.is_full  = (fill == CAPACITY);
      if (fill != 0) begin
         o.front_value = ring[4'(head)];
         o.back_value  = ring[4'((head + fill - 1) % CAPACITY)];
      end
      return o;
   endfunction

   // mostly values from a small pool so searches hit, now and then any word
   function automatic logic signed [31:0] pick_value();
      if ($urandom_range(99) < 75)
         return value_pool[3'($urandom_range(7))];
      return $urandom;
   endfunction

   task automatic queue_random_reqs(input int n);
      op_mix_type mix;
      req_type    r;
      int         roll;
      mix = MIX_EVEN;
      for (int i = 0; i < n; i++) begin
         // new op mix every couple dozen words, so the store swings full and empty
         if (i % 24 == 0)
            mix = op_mix_type'($urandom_range(2));
         roll = $urandom_range(99);
         r.value = pick_value();
         case (mix)
            MIX_FILL:
               r.op = (roll < 60) ? ($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK) :
                      (roll < 85) ? ($urandom_range(1) ? OP_CONTAINS : OP_REMOVE) :
                      ($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK);
            MIX_DRAIN:
               r.op = (roll < 55) ? ($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK) :
                      (roll < 75) ? ($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK) :
                      ($urandom_range(1) ? OP_CONTAINS : OP_REMOVE);
            default:
               r.op = (roll < 2) ? ($urandom_range(1) ? OP_UNUSED_A : OP_UNUSED_B) :
                      3'($urandom_range(5));
         endcase
         pending_reqs.push_back(r);
      end
   endtask

   // driver: a word is taken on an edge with start high and busy low
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            owed_rsps.push_back(deque_apply(req_data));
            void'(pending_reqs.pop_front());
         end
         // hold a word that is still waiting, else offer the next or idle
         if (start && busy) begin
         end else if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
            start    <= 1'b1;
            req_data <= pending_reqs[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: every strobed word against the oldest owed one
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (owed_rsps.size() == 0) begin
            log_mismatch("result word with none owed");
         end else begin
            due_rsp = owed_rsps.pop_front();
            field_check("status", 32'(rsp_data.status), 32'(due_rsp.status));
            field_check("found", 32'(rsp_data.found), 32'(due_rsp.found));
            field_check("count", 32'(rsp_data.count), 32'(due_rsp.count));
            field_check("is_empty", 32'(rsp_data.is_empty), 32'(due_rsp.is_empty));
            field_check("is_full", 32'(rsp_data.is_full), 32'(due_rsp.is_full));
            field_check("front_value", rsp_data.front_value, due_rsp.front_value);
            field_check("back_value", rsp_data.back_value, due_rsp.back_value);
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic signed [31:0] back_word;
      logic signed [31:0] v;
      value_pool[0] = 32'sh8000_0000;
      value_pool[1] = 32'sh7FFF_FFFF;
      value_pool[2] = -32'sd1;
      value_pool[3] = 32'sd0;
      for (int i = 4; i < 8; i++)
         value_pool[3'(i)] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty store: pops refused, searches miss, unused ops
      pending_reqs.push_back('{op: OP_POP_FRONT, value: 32'sd0});
      pending_reqs.push_back('{op: OP_POP_BACK, value: 32'sd0});
      pending_reqs.push_back('{op: OP_CONTAINS, value: 32'sd0});
      pending_reqs.push_back('{op: OP_REMOVE, value: 32'sd0});
      pending_reqs.push_back('{op: OP_UNUSED_A, value: $urandom});
      pending_reqs.push_back('{op: OP_UNUSED_B, value: $urandom});
      // fill from both ends, extremes first
      back_word = 32'sd0;
      for (int i = 0; i < CAPACITY; i++) begin
         v = (i < 4) ? value_pool[3'(i)] : $urandom;
         if (i % 2 == 0) begin
            pending_reqs.push_back('{op: OP_PUSH_FRONT, value: v});
         end else begin
            pending_reqs.push_back('{op: OP_PUSH_BACK, value: v});
            back_word = v;
         end
      end
      // full store: push refused, search to the far end, miss, remove midway
      pending_reqs.push_back('{op: OP_PUSH_BACK, value: 32'sh5555_5555});
      pending_reqs.push_back('{op: OP_CONTAINS, value: back_word});
      pending_reqs.push_back('{op: OP_REMOVE, value: 32'sh1234_5678});
      pending_reqs.push_back('{op: OP_REMOVE, value: value_pool[0]});
      while (pending_reqs.size() != 0) @(posedge clock);

      // random words under several sender gap rates
      gap_pct = 0;
      queue_random_reqs(300);
      while (pending_reqs.size() != 0) @(posedge clock);
      gap_pct = 72;
      queue_random_reqs(350);
      while (pending_reqs.size() != 0) @(posedge clock);
      gap_pct = 26;
      queue_random_reqs(300);
      while (pending_reqs.size() != 0) @(posedge clock);
      gap_pct = 0;
      queue_random_reqs(300);
      while (pending_reqs.size() != 0) @(posedge clock);

      // drain, then allow for a stray late word
      while (owed_rsps.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("deque_bag_store_top test passed");
      else
         $display("deque_bag_store_top test failed");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("deque_bag_store_top test failed");
      $finish;
   end

endmodule
